>>> hdl/spf_pkg.sv
`timescale 1ns / 1ps
package spf_pkg;
	localparam int STACK_DEPTH = 32;
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;
	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_ARP = 16'h0806;
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	typedef enum logic [4:0] {
		OP_UDP = 5'd0, OP_TCP = 5'd1, OP_ICMP = 5'd2, OP_ARP = 5'd3, OP_IP = 5'd4,
		OP_OR = 5'd5, OP_AND = 5'd6, OP_EQ = 5'd7, OP_NOT = 5'd8,
		OP_ADD = 5'd9, OP_SUB = 5'd10, OP_MUL = 5'd11, OP_DIV = 5'd12, OP_MOD = 5'd13,
		OP_ETO = 5'd14, OP_EFROM = 5'd15, OP_ETYPE = 5'd16, OP_IPTO = 5'd17,
		OP_IPFROM = 5'd18, OP_IPPROTO = 5'd19, OP_UDPTO = 5'd20, OP_UDPFROM = 5'd21,
		OP_TCPTO = 5'd22, OP_TCPFROM = 5'd23, OP_ICMPTYPE = 5'd24, OP_IMM = 5'd25
	} op_t;

	typedef struct packed {
		logic [4:0]  func;
		logic [47:0] imm;
		logic        last;
		logic [15:0] ethertype;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [31:0] ip_source;
		logic [31:0] ip_dest;
		logic [7:0]  ip_protocol;
		logic [15:0] l4_word0;
		logic [15:0] l4_word1;
		logic        first_token;
	} token_t;

	typedef struct packed {
		logic accept;
		logic stack_error;
	} verdict_t;
endpackage

>>> hdl/spf_if.sv
`timescale 1ns / 1ps
interface spf_tok_if;
	import spf_pkg::*;
	logic   valid;
	logic   ready;
	token_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spf_res_if;
	import spf_pkg::*;
	logic     valid;
	logic     ready;
	verdict_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/stack_packet_filter_eval_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// tok      in   token_t: opcode, immediate, flags, parsed header fields
// res      out  verdict_t: accept, stack_error (one beat per last token)
// Pushes, logic ops, add/sub, not and stack errors step through read,
// execute, write back and idle from one token beat to the next.
// Multiply sums three 32x32 partial products for the low 64 bits, then writes back.
// Divide/modulo form 64 quotient bits at one per cycle, then select.
// Bottom entry kept in a register so first_token clears the stack at once:
// entries above the level are never read before being pushed.
// Reset clears level, error flag and handshakes. A waiting result blocks
// only the next last token.
module stack_packet_filter_eval_unit import spf_pkg::*; (
	input logic clk,
	input logic arst_n,
	spf_tok_if.sink tok,
	spf_res_if.source res
);
	typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_WB} state_t;

	state_t           state_q;
	token_t           tok_q;
	logic [LVL_W-1:0] level_q;
	logic             err_q;
	logic [63:0]      bottom_q;
	logic [63:0]      mem [STACK_DEPTH];
	logic [63:0]      rd_a_q, rd_b_q;
	logic [IDX_W-1:0] ra_idx, rb_idx;
	logic [63:0]      a_v, b_v, res_q;
	logic [63:0]      opa_q, opb_q;
	logic [1:0]       mstep_q;
	logic [63:0]      macc_q;
	logic [31:0]      mul_x, mul_y;
	logic [63:0]      mul_p, mul_term;
	logic [6:0]       dcnt_q;
	logic [63:0]      quo_q, rem_q;
	logic             is_ip, is_udp, is_tcp, is_icmp;
	logic             is_push, is_bin, is_not;
	logic [63:0]      push_v;
	logic [LVL_W-1:0] lvl_eff;
	logic [64:0]      rtrial;
	logic [IDX_W-1:0] wb_idx;
	logic             wb_ok;

	assign tok.ready = (state_q == S_IDLE) && !(res.valid && tok.data.last);

	// header classification from the held token
	assign is_ip   = tok_q.ethertype == ETH_IPV4;
	assign is_udp  = is_ip && tok_q.ip_protocol == PROTO_UDP;
	assign is_tcp  = is_ip && tok_q.ip_protocol == PROTO_TCP;
	assign is_icmp = is_ip && tok_q.ip_protocol == PROTO_ICMP;
	assign lvl_eff = tok_q.first_token ? '0 : level_q;

	always_comb begin
		is_push = 1'b1;
		is_bin  = 1'b0;
		is_not  = 1'b0;
		push_v  = '0;
		case (tok_q.func)
			OP_UDP:      push_v = {63'd0, is_udp};
			OP_TCP:      push_v = {63'd0, is_tcp};
			OP_ICMP:     push_v = {63'd0, is_icmp};
			OP_ARP:      push_v = {63'd0, tok_q.ethertype == ETH_ARP};
			OP_IP:       push_v = {63'd0, is_ip};
			OP_OR, OP_AND, OP_EQ, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				is_push = 1'b0;
				is_bin  = 1'b1;
			end
			OP_NOT: begin
				is_push = 1'b0;
				is_not  = 1'b1;
			end
			OP_ETO:      push_v = {16'd0, tok_q.dst_mac};
			OP_EFROM:    push_v = {16'd0, tok_q.src_mac};
			OP_ETYPE:    push_v = {48'd0, tok_q.ethertype};
			OP_IPTO:     push_v = is_ip ? {32'd0, tok_q.ip_dest} : '0;
			OP_IPFROM:   push_v = is_ip ? {32'd0, tok_q.ip_source} : '0;
			OP_IPPROTO:  push_v = is_ip ? {56'd0, tok_q.ip_protocol} : '0;
			OP_UDPTO:    push_v = is_udp ? {48'd0, tok_q.l4_word1} : '0;
			OP_UDPFROM:  push_v = is_udp ? {48'd0, tok_q.l4_word0} : '0;
			OP_TCPTO:    push_v = is_tcp ? {48'd0, tok_q.l4_word1} : '0;
			OP_TCPFROM:  push_v = is_tcp ? {48'd0, tok_q.l4_word0} : '0;
			OP_ICMPTYPE: push_v = is_icmp ? {56'd0, tok_q.l4_word0[15:8]} : '0;
			OP_IMM:      push_v = {16'd0, tok_q.imm};
			default:     is_push = 1'b0;
		endcase
	end

	// operand addresses: level-2 and level-1
	assign ra_idx = IDX_W'(lvl_eff - LVL_W'(2));
	assign rb_idx = IDX_W'(lvl_eff - LVL_W'(1));
	// entry 0 lives in bottom_q
	assign a_v = (ra_idx == '0) ? bottom_q : rd_a_q;
	assign b_v = (rb_idx == '0) ? bottom_q : rd_b_q;
	assign rtrial = {rem_q, quo_q[63]} - {1'b0, opb_q};

	// partial products of the low 64 bits: lo*lo, hi*lo, lo*hi
	assign mul_x    = (mstep_q == 2'd1) ? opa_q[63:32] : opa_q[31:0];
	assign mul_y    = (mstep_q == 2'd2) ? opb_q[63:32] : opb_q[31:0];
	assign mul_p    = mul_x * mul_y;
	assign mul_term = (mstep_q == 2'd0) ? mul_p : {mul_p[31:0], 32'd0};

	// stack memory, two read ports, one write
	always_ff @(posedge clk) begin
		rd_a_q <= mem[ra_idx];
		rd_b_q <= mem[rb_idx];
		if (state_q == S_WB && wb_ok)
			mem[wb_idx] <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tok_q     <= '0;
			level_q   <= '0;
			err_q     <= 1'b0;
			bottom_q  <= '0;
			res_q     <= '0;
			opa_q     <= '0;
			opb_q     <= '0;
			mstep_q   <= '0;
			macc_q    <= '0;
			dcnt_q    <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			wb_idx    <= '0;
			wb_ok     <= 1'b0;
			res.valid <= 1'b0;
			res.data  <= '0;
		end else begin
			if (res.valid && res.ready)
				res.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (tok.valid && tok.ready) begin
						tok_q   <= tok.data;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (tok_q.first_token) begin
						level_q  <= '0;
						err_q    <= 1'b0;
						bottom_q <= '0;
					end
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					wb_ok   <= 1'b0;
					state_q <= S_WB;
					if (is_push) begin
						if (level_q >= LVL_W'(STACK_DEPTH)) err_q <= 1'b1;
						else begin
							res_q   <= push_v;
							wb_idx  <= IDX_W'(level_q);
							wb_ok   <= 1'b1;
							level_q <= level_q + LVL_W'(1);
						end
					end else if (is_not) begin
						if (level_q == '0) err_q <= 1'b1;
						else begin
							res_q  <= {63'd0, b_v == '0};
							wb_idx <= rb_idx;
							wb_ok  <= 1'b1;
						end
					end else if (is_bin) begin
						if (level_q < LVL_W'(2)) err_q <= 1'b1;
						else begin
							wb_idx  <= ra_idx;
							wb_ok   <= 1'b1;
							level_q <= level_q - LVL_W'(1);
							opa_q   <= a_v;
							opb_q   <= b_v;
							case (tok_q.func)
								OP_OR:  res_q <= {63'd0, (a_v != '0) || (b_v != '0)};
								OP_AND: res_q <= {63'd0, (a_v != '0) && (b_v != '0)};
								OP_EQ:  res_q <= {63'd0, a_v == b_v};
								OP_ADD: res_q <= a_v + b_v;
								OP_SUB: res_q <= a_v - b_v;
								OP_MUL: begin
									macc_q  <= '0;
									mstep_q <= '0;
									state_q <= S_MUL;
								end
								default: begin
									quo_q   <= a_v;
									rem_q   <= '0;
									dcnt_q  <= '0;
									state_q <= S_DIV;
								end
							endcase
						end
					end
				end
				S_MUL: begin
					// one 32x32 partial product per cycle
					if (mstep_q == 2'd2) begin
						res_q   <= macc_q + mul_term;
						state_q <= S_WB;
					end else begin
						macc_q  <= macc_q + mul_term;
						mstep_q <= mstep_q + 2'd1;
					end
				end
				S_DIV: begin
					// restoring divide, one bit per cycle
					if (dcnt_q == 7'd64) begin
						if (opb_q == '0) res_q <= '0;
						else res_q <= (tok_q.func == OP_DIV) ? quo_q : rem_q;
						state_q <= S_WB;
					end else begin
						if (!rtrial[64]) begin
							rem_q <= rtrial[63:0];
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= {rem_q[62:0], quo_q[63]};
							quo_q <= {quo_q[62:0], 1'b0};
						end
						dcnt_q <= dcnt_q + 7'd1;
					end
				end
				S_WB: begin
					if (wb_ok && wb_idx == '0)
						bottom_q <= res_q;
					if (tok_q.last) begin
						res.valid            <= 1'b1;
						res.data.stack_error <= err_q;
						res.data.accept      <= !err_q
							&& (((wb_ok && wb_idx == '0) ? res_q : bottom_q) != '0);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// assertions
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(STACK_DEPTH)) else $error("stack level out of range");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		tok.ready |-> state_q == S_IDLE) else $error("token taken while busy");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid) else $error("result dropped");
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> $stable(res.data)) else $error("result changed");
endmodule
